// File: rtl/ddik_pkg.sv
// ddik_pkg: shared types, register codes, reset values and constants for the
// differential drive inverse kinematics block
// no dependencies
package ddik_pkg;

	localparam int SPEED_BITS_DEF = 16;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 16;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WHEEL_SPACING = 2'd0,
		REG_MAX_LINEAR    = 2'd1,
		REG_MAX_ANGULAR   = 2'd2,
		REG_MIN_RADIUS    = 2'd3
	} cfg_reg_t;

	localparam int SPACING_BITS = 12;
	localparam int LIMIT_BITS   = 15;
	localparam int RADIUS_BITS  = 16;

	localparam logic [SPACING_BITS-1:0] SPACING_RST = 12'd150;
	localparam logic [LIMIT_BITS-1:0]   MAX_LIN_RST = 15'd500;
	localparam logic [LIMIT_BITS-1:0]   MAX_ANG_RST = 15'd3000;
	localparam logic [RADIUS_BITS-1:0]  MIN_RAD_RST = 16'd200;

	// clamped magnitudes never exceed 32768
	localparam int MAG_BITS = 16;
	// |fwd| * 1000 stays below 2^26
	localparam int PRODF_BITS = 26;
	localparam int PRODR_BITS = 32;

	// radius divider: 16 quotient bits, four per stage
	localparam int DIV_STAGES = 4;
	localparam int DIV_STEPS  = 4;

	// floor(y / 125) for y < 2^24 via floor(2^31 / 125) and one correction
	localparam int                RECIP_SHIFT = 31;
	localparam logic [24:0]       RECIP_125   = 25'd17179869;
	localparam logic [24:0]       DIVISOR_125 = 25'd125;

	typedef struct packed {
		logic                fneg;
		logic [MAG_BITS-1:0] afwd;
		logic                tneg;
		logic [MAG_BITS-1:0] aturn;
	} cmd_mag_t;

	// partial remainder and dividend bits shifting out / quotient shifting in
	typedef struct packed {
		logic [RADIUS_BITS-1:0] rem;
		logic [MAG_BITS-1:0]    wrk;
	} div_t;

	function automatic div_t div_step(input div_t d, input logic [RADIUS_BITS-1:0] dvs);
		logic [RADIUS_BITS:0] t;
		div_t                 r;
		t = {d.rem, d.wrk[MAG_BITS-1]};
		if (t >= {1'b0, dvs}) begin
			r.rem = RADIUS_BITS'(t - {1'b0, dvs});
			r.wrk = {d.wrk[MAG_BITS-2:0], 1'b1};
		end else begin
			r.rem = t[RADIUS_BITS-1:0];
			r.wrk = {d.wrk[MAG_BITS-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

// File: rtl/ddik_cmd_if.sv
// ddik_cmd_if, ddik_wheel_if: valid/ready channels for chassis commands and
// wheel speeds
// depends on ddik_pkg
interface ddik_cmd_if import ddik_pkg::*; #(parameter int SPEED_BITS = SPEED_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [SPEED_BITS-1:0] forward_speed;
	logic signed [SPEED_BITS-1:0] turn_rate;

	modport source (output valid, output forward_speed, output turn_rate, input ready);
	modport sink   (input valid, input forward_speed, input turn_rate, output ready);
endinterface

interface ddik_wheel_if import ddik_pkg::*; #(parameter int SPEED_BITS = SPEED_BITS_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [SPEED_BITS-1:0] left_speed;
	logic signed [SPEED_BITS-1:0] right_speed;

	modport source (output valid, output left_speed, output right_speed, input ready);
	modport sink   (input valid, input left_speed, input right_speed, output ready);
endinterface

// File: rtl/diff_drive_inverse_kinematics_top.sv
// diff_drive_inverse_kinematics_top: chassis command to wheel speeds, ten stage pipeline
// depends on ddik_pkg and the channel interfaces in ddik_cmd_if.sv
//
//  channel  dir  payload                            beat taken when
//  cmd      in   forward_speed, turn_rate           cmd.valid & cmd.ready
//  wheel    out  left_speed, right_speed            wheel.valid & wheel.ready
//  cfg      in   cfg_index, cfg_data                cfg_we
//
// one beat enters per cycle while the pipe advances; results leave from stage ten, the output register
// the whole pipe advances as one: it moves whenever the output register is empty or taken
// a stall freezes every stage, so bubbles and beats are neither lost nor repeated
// arst_n clears the valid bits and loads the register reset values
// registers are read live by the stages, so write them only with the pipe empty
module diff_drive_inverse_kinematics_top import ddik_pkg::*; #(
	parameter int SPEED_BITS = SPEED_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	ddik_cmd_if.sink                 cmd,
	ddik_wheel_if.source             wheel
);

	// working width for the input clamp: input or limit, plus a sign
	localparam int CW       = ((SPEED_BITS > MAG_BITS) ? SPEED_BITS : MAG_BITS) + 1;
	localparam int PROD_BITS = MAG_BITS + SPACING_BITS;   // |turn| * spacing
	localparam int Y_BITS    = PROD_BITS - 4;             // after the divide by 16
	localparam int P_BITS    = Y_BITS + 25;
	localparam int Q_BITS    = P_BITS - RECIP_SHIFT;
	localparam int SUM_BITS  = Q_BITS + 1;

	// configuration registers
	logic [SPACING_BITS-1:0] spacing_q;
	logic [LIMIT_BITS-1:0]   max_lin_q;
	logic [LIMIT_BITS-1:0]   max_ang_q;
	logic [RADIUS_BITS-1:0]  min_rad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spacing_q <= SPACING_RST;
			max_lin_q <= MAX_LIN_RST;
			max_ang_q <= MAX_ANG_RST;
			min_rad_q <= MIN_RAD_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WHEEL_SPACING: spacing_q <= cfg_data[SPACING_BITS-1:0];
				REG_MAX_LINEAR:    max_lin_q <= cfg_data[LIMIT_BITS-1:0];
				REG_MAX_ANGULAR:   max_ang_q <= cfg_data[LIMIT_BITS-1:0];
				REG_MIN_RADIUS:    min_rad_q <= cfg_data[RADIUS_BITS-1:0];
				default: ;
			endcase
		end
	end

	// pipe advance
	logic adv;
	logic v_s1, v_s2, v_s7, v_s8, v_s9, v_s10;
	logic [DIV_STAGES-1:0] v_dv;   // stages three to six

	assign adv       = !v_s10 || wheel.ready;
	assign cmd.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_dv  <= '0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s1  <= cmd.valid;
			v_s2  <= v_s1;
			v_dv  <= {v_dv[DIV_STAGES-2:0], v_s2};
			v_s7  <= v_dv[DIV_STAGES-1];
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// stage 1: clamp both inputs and split into sign and magnitude
	logic signed [CW-1:0] fwd_x, turn_x, lin_x, ang_x, fwd_c, turn_c, fwd_m, turn_m;
	cmd_mag_t             mag_c;
	cmd_mag_t             mag_s1;

	always_comb begin
		fwd_x  = CW'(cmd.forward_speed);
		turn_x = CW'(cmd.turn_rate);
		lin_x  = signed'(CW'(max_lin_q));
		ang_x  = signed'(CW'(max_ang_q));
		if (fwd_x > lin_x)        fwd_c = lin_x;
		else if (fwd_x < -lin_x)  fwd_c = -lin_x;
		else                      fwd_c = fwd_x;
		if (turn_x > ang_x)       turn_c = ang_x;
		else if (turn_x < -ang_x) turn_c = -ang_x;
		else                      turn_c = turn_x;
		fwd_m       = fwd_c[CW-1] ? -fwd_c : fwd_c;
		turn_m      = turn_c[CW-1] ? -turn_c : turn_c;
		mag_c.fneg  = fwd_c[CW-1];
		mag_c.afwd  = fwd_m[MAG_BITS-1:0];
		mag_c.tneg  = turn_c[CW-1];
		mag_c.aturn = turn_m[MAG_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) mag_s1 <= mag_c;
	end

	// stage 2: the two sides of the radius test
	logic [PRODF_BITS-1:0] prodf_s2;
	logic [PRODR_BITS-1:0] prodr_s2;
	cmd_mag_t              mag_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			prodf_s2 <= PRODF_BITS'(mag_s1.afwd * 10'd1000);
			prodr_s2 <= PRODR_BITS'(min_rad_q * mag_s1.aturn);
			mag_s2   <= mag_s1;
		end
	end

	// stages 3 to 6: |fwd| * 1000 / min_radius, four quotient bits a stage
	// only the low 16 quotient bits are formed; exact whenever the limit applies
	div_t     dv_s3to6  [DIV_STAGES];
	cmd_mag_t mag_s3to6 [DIV_STAGES];
	logic     lim_s3to6 [DIV_STAGES];
	logic     lim_c;
	div_t     dv_start;

	assign lim_c = (mag_s2.aturn > MAG_BITS'(1)) && (mag_s2.afwd > MAG_BITS'(1)) &&
	               (PRODR_BITS'(prodf_s2) < prodr_s2);
	assign dv_start.rem = RADIUS_BITS'(prodf_s2[PRODF_BITS-1:MAG_BITS]);
	assign dv_start.wrk = prodf_s2[MAG_BITS-1:0];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		div_t     dv_in, dv_out;
		cmd_mag_t mag_in;
		logic     lim_in;

		if (g == 0) begin : g_first
			assign dv_in  = dv_start;
			assign mag_in = mag_s2;
			assign lim_in = lim_c;
		end else begin : g_next
			assign dv_in  = dv_s3to6[g-1];
			assign mag_in = mag_s3to6[g-1];
			assign lim_in = lim_s3to6[g-1];
		end

		always_comb begin
			dv_out = dv_in;
			for (int k = 0; k < DIV_STEPS; k++) begin
				dv_out = div_step(dv_out, min_rad_q);
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s3to6[g]  <= dv_out;
				mag_s3to6[g] <= mag_in;
				lim_s3to6[g] <= lim_in;
			end
		end
	end

	// stage 7: pick the turn magnitude, multiply by the spacing
	logic [PROD_BITS-1:0] prod_s7;
	cmd_mag_t             mag_s7;
	logic [MAG_BITS-1:0]  tmag;

	assign tmag = lim_s3to6[DIV_STAGES-1] ? dv_s3to6[DIV_STAGES-1].wrk
	                                      : mag_s3to6[DIV_STAGES-1].aturn;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s7 <= PROD_BITS'(tmag * spacing_q);
			mag_s7  <= mag_s3to6[DIV_STAGES-1];
		end
	end

	// stage 8: divide by 2000 = shift by 4, then reciprocal of 125
	logic [Y_BITS-1:0] y_s8;
	logic [P_BITS-1:0] p_s8;
	cmd_mag_t          mag_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			y_s8   <= prod_s7[PROD_BITS-1:4];
			p_s8   <= P_BITS'(prod_s7[PROD_BITS-1:4] * RECIP_125);
			mag_s8 <= mag_s7;
		end
	end

	// stage 9: estimate is at most one short, one compare fixes it
	logic [Q_BITS-1:0] q_est;
	logic [24:0]       r_est;
	logic [Q_BITS-1:0] half_s9;
	cmd_mag_t          mag_s9;

	assign q_est = p_s8[P_BITS-1:RECIP_SHIFT];
	assign r_est = 25'(y_s8) - 25'(25'(q_est) * DIVISOR_125);

	always_ff @(posedge clk) begin
		if (adv) begin
			half_s9 <= (r_est >= DIVISOR_125) ? q_est + Q_BITS'(1) : q_est;
			mag_s9  <= mag_s8;
		end
	end

	// stage 10: wheel sums, clamp, output register
	logic signed [SUM_BITS-1:0] fwd_v, half_v, lin_v, left_v, right_v, left_c, right_c;
	logic signed [SPEED_BITS-1:0] left_s10, right_s10;

	always_comb begin
		fwd_v   = signed'(SUM_BITS'(mag_s9.afwd));
		fwd_v   = mag_s9.fneg ? -fwd_v : fwd_v;
		half_v  = signed'(SUM_BITS'(half_s9));
		half_v  = mag_s9.tneg ? -half_v : half_v;
		lin_v   = signed'(SUM_BITS'(max_lin_q));
		left_v  = fwd_v - half_v;
		right_v = fwd_v + half_v;
		if (left_v > lin_v)        left_c = lin_v;
		else if (left_v < -lin_v)  left_c = -lin_v;
		else                       left_c = left_v;
		if (right_v > lin_v)       right_c = lin_v;
		else if (right_v < -lin_v) right_c = -lin_v;
		else                       right_c = right_v;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			left_s10  <= SPEED_BITS'(left_c);
			right_s10 <= SPEED_BITS'(right_c);
		end
	end

	assign wheel.valid       = v_s10;
	assign wheel.left_speed  = left_s10;
	assign wheel.right_speed = right_s10;

	// a limited turn rate is always below the clamped one
	a_lim_quot: assert property (@(posedge clk) disable iff (!arst_n)
		(v_dv[DIV_STAGES-1] && lim_s3to6[DIV_STAGES-1]) |->
		(dv_s3to6[DIV_STAGES-1].wrk < mag_s3to6[DIV_STAGES-1].aturn))
		else $error("radius quotient not below turn magnitude");

	// reciprocal estimate never more than one short
	a_recip: assert property (@(posedge clk) disable iff (!arst_n)
		v_s8 |-> (r_est < 25'd250))
		else $error("divide by 2000 estimate out of range");

	// a stall freezes the middle of the pipe
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s7) && $stable(v_dv)))
		else $error("pipe moved while stalled");

endmodule

// File: bench/tb_diff_drive_inverse_kinematics_top.sv
`timescale 1ns / 100ps
// tb_diff_drive_inverse_kinematics_top: self-checking bench for the wheel speed pipeline
// predicts left and right wheel speeds per chassis command and checks every wheel beat
// depends on ddik_pkg, the channel interfaces and diff_drive_inverse_kinematics_top
module tb_diff_drive_inverse_kinematics_top import ddik_pkg::*; ();

	localparam int W             = SPEED_BITS_DEF;
	localparam int PHASE_ITEMS   = 95;
	localparam int TAIL_CYCLES   = 16;
	localparam int CYCLE_LIMIT   = 500000;

	typedef struct packed {
		logic signed [W-1:0] forward_speed;
		logic signed [W-1:0] turn_rate;
	} chassis_cmd_t;

	typedef struct packed {
		logic signed [W-1:0] left_speed;
		logic signed [W-1:0] right_speed;
	} wheel_speeds_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// everything the bench drives, known from time zero
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
	logic                     cmd_valid = 1'b0;
	logic signed [W-1:0]      cmd_fwd   = '0;
	logic signed [W-1:0]      cmd_turn  = '0;
	logic                     wheel_ready = 1'b0;

	ddik_cmd_if   #(.SPEED_BITS(W)) cmd_ch ();
	ddik_wheel_if #(.SPEED_BITS(W)) wheel_ch ();

	assign cmd_ch.valid         = cmd_valid;
	assign cmd_ch.forward_speed = cmd_fwd;
	assign cmd_ch.turn_rate     = cmd_turn;
	assign wheel_ch.ready       = wheel_ready;

	diff_drive_inverse_kinematics_top #(.SPEED_BITS(W)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.wheel     (wheel_ch)
	);

	// bench copy of the register file, same reset values as the block
	logic [SPACING_BITS-1:0] spacing_mm = SPACING_RST;
	logic [LIMIT_BITS-1:0]   lin_limit  = MAX_LIN_RST;
	logic [LIMIT_BITS-1:0]   ang_limit  = MAX_ANG_RST;
	logic [RADIUS_BITS-1:0]  min_radius = MIN_RAD_RST;

	chassis_cmd_t  cmd_backlog[$];   // commands still to be offered
	wheel_speeds_t wheels_due[$];    // predicted wheel beats, oldest first
	wheel_speeds_t due_wheels;

	logic cmd_taken  = 1'b0;
	int   mismatches = 0;
	int   cycles     = 0;

	// sender pacing
	int   burst_left = 1;
	int   gap_left   = 0;
	bit   drain_hold = 1'b0;

	// receiver stall pattern
	logic [15:0] stall_pattern = 16'hFFFF;
	int          stall_age     = 0;

	function automatic longint clamp_mag(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	// wheel speeds for one command under the current register values
	function automatic wheel_speeds_t predict_wheels(input chassis_cmd_t c);
		longint        lin_lim;
		longint        fwd;
		longint        turn;
		longint        afwd;
		longint        aturn;
		longint        capped;
		longint        half;
		wheel_speeds_t w;
		lin_lim = longint'(lin_limit);
		fwd     = clamp_mag(longint'(c.forward_speed), lin_lim);
		turn    = clamp_mag(longint'(c.turn_rate), longint'(ang_limit));
		afwd    = (fwd < 0) ? -fwd : fwd;
		aturn   = (turn < 0) ? -turn : turn;
		// turn tighter than the minimum radius: shrink the rate to that radius
		if (aturn > 1 && afwd > 1 && afwd * 1000 < longint'(min_radius) * aturn) begin
			capped = (afwd * 1000) / longint'(min_radius);
			turn   = (turn < 0) ? -capped : capped;
		end
		// signed division truncates toward zero
		half = (turn * longint'(spacing_mm)) / 2000;
		w.left_speed  = W'(clamp_mag(fwd - half, lin_lim));
		w.right_speed = W'(clamp_mag(fwd + half, lin_lim));
		return w;
	endfunction

	task automatic queue_cmd(input int fwd, input int turn);
		chassis_cmd_t c;
		c.forward_speed = W'(fwd);
		c.turn_rate     = W'(turn);
		cmd_backlog.push_back(c);
	endtask

	// speed or rate value aimed at the interesting spots around a limit
	function automatic int pick_speed(input int lim);
		int v;
		case ($urandom_range(0, 7))
			0, 1: v = int'($urandom_range(0, 65535));
			2: v = lim + $urandom_range(0, 4) - 2;
			3: v = $urandom_range(0, 6) - 3;
			4: v = $urandom_range(0, 1) ? 32767 : -32768;
			default: v = $urandom_range(0, lim);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic queue_random(input int n);
		for (int i = 0; i < n; i++)
			queue_cmd(pick_speed(int'(lin_limit)), pick_speed(int'(ang_limit)));
	endtask

	// all four registers, written back to back at falling edges
	task automatic set_config(input logic [15:0] spacing, input logic [15:0] lin,
			input logic [15:0] ang, input logic [15:0] radius);
		@(negedge clk);
		cfg_we = 1'b1; cfg_index = REG_WHEEL_SPACING; cfg_data = spacing;
		spacing_mm = spacing[SPACING_BITS-1:0];
		@(negedge clk);
		cfg_index = REG_MAX_LINEAR; cfg_data = lin;
		lin_limit = lin[LIMIT_BITS-1:0];
		@(negedge clk);
		cfg_index = REG_MAX_ANGULAR; cfg_data = ang;
		ang_limit = ang[LIMIT_BITS-1:0];
		@(negedge clk);
		cfg_index = REG_MIN_RADIUS; cfg_data = radius;
		min_radius = radius[RADIUS_BITS-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// wait for the pipe to empty, then let it settle
	task automatic settle();
		while (cmd_backlog.size() != 0 || cmd_valid || wheels_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// command driver: bursts of beats with random gaps, now and then a full drain
	always @(negedge clk) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (cmd_valid && !cmd_taken) begin
			// beat still waiting for ready, hold it
		end else if (gap_left > 0) begin
			gap_left--;
			cmd_valid <= 1'b0;
		end else if (drain_hold) begin
			// hold off until every predicted wheel beat has come back
			if (wheels_due.size() == 0)
				drain_hold = 1'b0;
			cmd_valid <= 1'b0;
		end else if (cmd_backlog.size() != 0) begin
			{cmd_fwd, cmd_turn} <= cmd_backlog.pop_front();
			cmd_valid <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				drain_hold = ($urandom_range(0, 15) == 0);
			end
		end else begin
			cmd_valid <= 1'b0;
		end
	end

	// wheel receiver: ready follows a rotating pattern, reloaded every so often
	always @(negedge clk) begin
		if (stall_age == 0) begin
			case ($urandom_range(0, 3))
				0: stall_pattern = 16'hFFFF;                      // no stalls at all
				1: stall_pattern = 16'($urandom) | 16'h1;
				2: stall_pattern = 16'($urandom | $urandom);      // light stalls
				default: stall_pattern = 16'($urandom & $urandom) | 16'h1;
			endcase
			stall_age = $urandom_range(16, 200);
		end else begin
			stall_age--;
		end
		wheel_ready   <= arst_n && stall_pattern[0];
		stall_pattern  = {stall_pattern[0], stall_pattern[15:1]};
	end

	// monitor: predict on every command beat, check every wheel beat
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && wheel_ready && wheel_ch.valid) begin
			if (wheels_due.size() == 0) begin
				$display("%0t: unexpected wheel beat expected none got left %0d right %0d",
					$time, wheel_ch.left_speed, wheel_ch.right_speed);
				mismatches++;
			end else begin
				due_wheels = wheels_due.pop_front();
				if (wheel_ch.left_speed !== due_wheels.left_speed) begin
					$display("%0t: left_speed expected %0d got %0d",
						$time, due_wheels.left_speed, wheel_ch.left_speed);
					mismatches++;
				end
				if (wheel_ch.right_speed !== due_wheels.right_speed) begin
					$display("%0t: right_speed expected %0d got %0d",
						$time, due_wheels.right_speed, wheel_ch.right_speed);
					mismatches++;
				end
			end
		end
		if (arst_n && cmd_valid && cmd_ch.ready) begin
			wheels_due.push_back(predict_wheels({cmd_fwd, cmd_turn}));
			cmd_taken <= 1'b1;
		end else begin
			cmd_taken <= 1'b0;
		end
	end

	// watchdog on the cycle count
	initial begin
		while (cycles < CYCLE_LIMIT)
			@(posedge clk);
		$display("[diff_drive_inverse_kinematics_top] ERROR");
		$finish;
	end

	// stimulus sequence
	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed commands on the reset register values
		queue_cmd(0, 0);
		queue_cmd(32767, 32767);
		queue_cmd(-32768, -32768);
		queue_cmd(32767, -32768);
		queue_cmd(-32768, 32767);
		queue_cmd(500, 0);
		queue_cmd(-501, 0);
		queue_cmd(0, 3000);
		queue_cmd(0, -3001);
		queue_cmd(0, -32768);
		queue_cmd(1, 3000);       // forward too slow for the radius limit
		queue_cmd(2, 3000);       // smallest forward speed that is limited
		queue_cmd(100, 2);        // smallest turn, radius fine
		queue_cmd(-1, -2);
		queue_cmd(200, 1000);     // exactly on the minimum radius
		queue_cmd(200, 1001);     // just inside it
		queue_cmd(300, -2500);    // limited, negative turn
		queue_cmd(-300, 2500);
		queue_cmd(450, -3000);    // limited turn still saturates a wheel
		queue_cmd(10, -7);        // half term truncates to zero
		queue_cmd(10, -14);       // negative half term truncates toward zero
		queue_random(PHASE_ITEMS);
		settle();

		// largest limits, tightest radius
		set_config(16'd4000, 16'd32767, 16'd32767, 16'd1);
		queue_random(PHASE_ITEMS);
		settle();

		// every register zero: no spacing, no radius test, speeds forced to zero
		set_config(16'd0, 16'd0, 16'd0, 16'd0);
		queue_random(PHASE_ITEMS);
		settle();

		// all-ones data but a turn limit of 1000, upper bits dropped by the narrower registers
		set_config(16'hFFFF, 16'hFFFF, 16'd1000, 16'hFFFF);
		queue_random(PHASE_ITEMS);
		settle();

		repeat (2) begin
			set_config(16'($urandom_range(1, 4000)), 16'($urandom_range(0, 32767)),
				16'($urandom_range(0, 32767)), 16'($urandom_range(1, 65535)));
			queue_random(PHASE_ITEMS);
			settle();
		end

		// narrowest spacing, radius limit off
		set_config(16'd1, 16'd32767, 16'd32767, 16'd0);
		queue_random(PHASE_ITEMS);
		settle();

		// no linear speed at all with a wide turn range
		set_config(16'd2000, 16'd0, 16'd32767, 16'd65535);
		queue_random(PHASE_ITEMS);
		settle();

		// back to the reset values
		set_config(16'(SPACING_RST), 16'(MAX_LIN_RST), 16'(MAX_ANG_RST), 16'(MIN_RAD_RST));
		queue_random(PHASE_ITEMS);
		settle();

		if (mismatches == 0)
			$display("[diff_drive_inverse_kinematics_top] OK");
		else
			$display("[diff_drive_inverse_kinematics_top] ERROR");
		$finish;
	end

endmodule
